FILE: rtl/rob_window_conflict_features_assert.svh
// Assertion macros for the reorder-buffer conflict feature block
`ifndef ROB_WINDOW_CONFLICT_FEATURES_ASSERT_SVH
`define ROB_WINDOW_CONFLICT_FEATURES_ASSERT_SVH
`ifndef SYNTHESIS
`define RWCF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RWCF_ASSERT(lbl, prop, msg) `RWCF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define RWCF_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define RWCF_ASSERT(lbl, prop, msg)
`endif
`endif

FILE: rtl/rwcf_pkg.sv
// Shared types and constants for the reorder-buffer conflict feature block
`timescale 1ns / 1ps
package rwcf_pkg;
  localparam int ROB_ENTRIES = 64;
  localparam int IDX_W = $clog2(ROB_ENTRIES);
  localparam int CNT_W = $clog2(ROB_ENTRIES + 1);
  localparam int TICK_W = 48;
  localparam int LINE_BITS = 6;
  localparam logic [3:0] MAX_RETIRE = 4'd8;
  localparam logic [3:0] RETIRE_LIMIT_RST = 4'd4;

  typedef enum logic [1:0] {
    FUNC_FETCH  = 2'd0,
    FUNC_SETCMP = 2'd1,
    FUNC_RETIRE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {S_IDLE, S_REPORT, S_RETIRE, S_RET_OUT} state_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_FROM_HI,
    CM_FROM_LO
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       tick_we;
  } cell_cmd_t;

  typedef struct packed {
    logic [63:0]       pc;
    logic              is_mem;
    logic [63:0]       addr_lo;
    logic [63:0]       addr_hi;
    logic [2:0][63:0]  iwalk;
    logic [2:0][63:0]  dwalk;
    logic [TICK_W-1:0] tick;
  } entry_t;
endpackage

FILE: rtl/rwcf_cell.sv
// One reorder-buffer cell: holds an entry and shifts it to either neighbor
`timescale 1ns / 1ps
module rwcf_cell import rwcf_pkg::*; (
  input  logic              clk_i,
  input  cell_cmd_t         cmd_i,
  input  entry_t            from_hi_i,
  input  entry_t            from_lo_i,
  input  logic [TICK_W-1:0] tick_i,
  output entry_t            entry_o
);
  entry_t entry_d, entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.mode)
      CM_FROM_HI: entry_d = from_hi_i;
      CM_FROM_LO: entry_d = from_lo_i;
      default:    entry_d = entry_q;
    endcase
    if (cmd_i.tick_we) begin
      entry_d.tick = tick_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
endmodule

FILE: rtl/rob_window_conflict_features.sv
// Top level: reorder-buffer chain with conflict feature reporting
`timescale 1ns / 1ps
`include "rob_window_conflict_features_assert.svh"
// A chain of 64 cells holds the entries, newest in the top cell. A fetch
// shifts the new entry in, then rotates the whole chain once around, one
// step per cycle unless the output stalls, comparing the top cell against
// the new entry: it gives one result per resident entry, newest first. A
// retire rotates the chain the other way and checks the oldest entries as
// they pass the top cell. Set-complete, a rejected fetch and an unknown
// func give one result each.
module rob_window_conflict_features import rwcf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic [63:0]       pc_i,
  input  logic              is_mem_i,
  input  logic [63:0]       data_addr_i,
  input  logic [63:0]       data_addr_end_i,
  input  logic [63:0]       iwalk_0_i,
  input  logic [63:0]       iwalk_1_i,
  input  logic [63:0]       iwalk_2_i,
  input  logic [63:0]       dwalk_0_i,
  input  logic [63:0]       dwalk_1_i,
  input  logic [63:0]       dwalk_2_i,
  input  logic [47:0]       tick_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [5:0]        entry_pos_o,
  output logic              pc_match_o,
  output logic [1:0]        ipage_count_o,
  output logic              data_overlap_o,
  output logic              data_line_match_o,
  output logic [1:0]        dpage_count_o,
  output logic [3:0]        retired_count_o,
  output logic [6:0]        occupancy_o,
  output logic              rejected_o,
  output logic              last_o
);
  localparam logic [CNT_W-1:0] NENT = CNT_W'(ROB_ENTRIES);

  typedef struct packed {
    logic [5:0] pos;
    logic       pcm;
    logic [1:0] ipc;
    logic       ovl;
    logic       line;
    logic [1:0] dpc;
    logic [3:0] ret;
    logic [6:0] occ;
    logic       rej;
    logic       lst;
  } result_t;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d, k_q, k_d;
  logic [3:0]        limit_q, limit_d, done_q, done_d;
  logic              active_q, active_d;
  logic [TICK_W-1:0] optick_q, optick_d;
  entry_t            new_q, new_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;

  cell_cmd_t         cmd [ROB_ENTRIES];
  entry_t            cells [ROB_ENTRIES];
  entry_t            top_in;
  logic              top_fetch;
  entry_t            probe, new_in;
  logic              acc, out_free, both;
  logic [3:0]        lim_eff;
  logic [CNT_W-1:0]  ret_dist;
  logic [2:0]        im, dm;
  cell_mode_e        chain_mode;
  logic              tick_we;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign acc = in_valid_i && !in_stall_o;
  assign probe = cells[ROB_ENTRIES-1];
  assign lim_eff = (limit_q > MAX_RETIRE) ? MAX_RETIRE : limit_q;
  assign ret_dist = NENT - k_q;

  // new entry takes the tick of the cell falling off the bottom (reused slot)
  always_comb begin
    new_in.pc      = pc_i;
    new_in.is_mem  = is_mem_i;
    new_in.addr_lo = data_addr_i;
    new_in.addr_hi = data_addr_end_i;
    new_in.iwalk   = {iwalk_2_i, iwalk_1_i, iwalk_0_i};
    new_in.dwalk   = {dwalk_2_i, dwalk_1_i, dwalk_0_i};
    new_in.tick    = cells[0].tick;
  end

  assign top_in = top_fetch ? new_in : cells[0];

  for (genvar i = 0; i < ROB_ENTRIES; i++) begin : g_cell
    assign cmd[i].mode = chain_mode;
    assign cmd[i].tick_we = (i == ROB_ENTRIES - 1) ? tick_we : 1'b0;
    rwcf_cell u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd[i]),
      .from_hi_i(i == ROB_ENTRIES - 1 ? top_in : cells[(i + 1) % ROB_ENTRIES]),
      .from_lo_i(cells[(i + ROB_ENTRIES - 1) % ROB_ENTRIES]),
      .tick_i   (tick_i),
      .entry_o  (cells[i])
    );
  end

  // conflict features of the top cell against the fetched entry
  always_comb begin
    both = new_q.is_mem && probe.is_mem;
    for (int j = 0; j < 3; j++) begin
      im[j] = (probe.iwalk[j] != '0) && (probe.iwalk[j] == new_q.iwalk[j]);
      dm[j] = both && (probe.dwalk[j] != '0) && (probe.dwalk[j] == new_q.dwalk[j]);
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    limit_d     = limit_q;
    done_d      = done_q;
    active_d    = active_q;
    optick_d    = optick_q;
    new_d       = new_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    chain_mode  = CM_HOLD;
    top_fetch   = 1'b0;
    tick_we     = 1'b0;

    if (cfg_we_i) begin
      limit_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          res_d = '0;
          res_d.lst = 1'b1;
          res_d.occ = count_q;
          unique case (func_e'(func_i))
            FUNC_FETCH: begin
              if (count_q == NENT) begin
                res_d.rej = 1'b1;
                out_valid_d = 1'b1;
              end else begin
                chain_mode = CM_FROM_HI;
                top_fetch  = 1'b1;
                new_d      = new_in;
                count_d    = count_q + 1'b1;
                k_d        = '0;
                state_d    = S_REPORT;
              end
            end
            FUNC_SETCMP: begin
              tick_we = (count_q != '0);
              out_valid_d = 1'b1;
            end
            FUNC_RETIRE: begin
              chain_mode = CM_FROM_HI;
              optick_d   = tick_i;
              k_d        = CNT_W'(1);
              done_d     = '0;
              active_d   = 1'b1;
              state_d    = S_RETIRE;
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      S_REPORT: begin
        if (k_q < count_q) begin
          if (out_free) begin
            res_d = '0;
            res_d.pos = k_q[IDX_W-1:0];
            res_d.occ = count_q;
            res_d.lst = (k_q == count_q - 1'b1);
            if (k_q != '0) begin
              res_d.pcm  = (probe.pc == new_q.pc);
              res_d.ipc  = {1'b0, im[0]} + {1'b0, im[1]} + {1'b0, im[2]};
              res_d.ovl  = both && (new_q.addr_hi >= probe.addr_lo) &&
                           (new_q.addr_lo <= probe.addr_hi);
              res_d.line = both && (new_q.addr_lo[63:LINE_BITS] ==
                                    probe.addr_lo[63:LINE_BITS]);
              res_d.dpc  = {1'b0, dm[0]} + {1'b0, dm[1]} + {1'b0, dm[2]};
            end
            out_valid_d = 1'b1;
            chain_mode  = CM_FROM_LO;
            k_d         = k_q + 1'b1;
            if (k_q == NENT - 1'b1) state_d = S_IDLE;
          end
        end else begin
          chain_mode = CM_FROM_LO;
          k_d        = k_q + 1'b1;
          if (k_q == NENT - 1'b1) state_d = S_IDLE;
        end
      end
      S_RETIRE: begin
        // top cell now holds the entry at distance ret_dist from the newest
        if (active_q && count_q != '0 && ret_dist == count_q - 1'b1) begin
          if (done_q < lim_eff && probe.tick <= optick_q) begin
            count_d = count_q - 1'b1;
            done_d  = done_q + 1'b1;
          end else begin
            active_d = 1'b0;
          end
        end
        if (k_q == NENT) begin
          state_d = S_RET_OUT;
        end else begin
          chain_mode = CM_FROM_HI;
          k_d = k_q + 1'b1;
        end
      end
      S_RET_OUT: begin
        if (out_free) begin
          res_d = '0;
          res_d.ret = done_q;
          res_d.occ = count_q;
          res_d.lst = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      limit_q     <= RETIRE_LIMIT_RST;
      done_q      <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      limit_q     <= limit_d;
      done_q      <= done_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    optick_q <= optick_d;
    new_q    <= new_d;
    res_q    <= res_d;
  end

  assign out_valid_o       = out_valid_q;
  assign entry_pos_o       = res_q.pos;
  assign pc_match_o        = res_q.pcm;
  assign ipage_count_o     = res_q.ipc;
  assign data_overlap_o    = res_q.ovl;
  assign data_line_match_o = res_q.line;
  assign dpage_count_o     = res_q.dpc;
  assign retired_count_o   = res_q.ret;
  assign occupancy_o       = res_q.occ;
  assign rejected_o        = res_q.rej;
  assign last_o            = res_q.lst;

  `RWCF_ASSERT(a_count_bound, count_q <= NENT, "occupancy above ring size")
  `RWCF_ASSERT(a_busy_stalls, (state_q != S_IDLE) |-> in_stall_o, "input taken while busy")
  `RWCF_ASSERT(a_ret_last, (state_q == S_RET_OUT && out_free) |=> (out_valid_q && res_q.lst),
               "retire result missing last")
  `RWCF_ASSERT(a_retire_bound, (state_q == S_RETIRE) |-> (done_q <= MAX_RETIRE),
               "retired more than allowed")
endmodule
